// ===== design/point_in_polygon_test_macros.svh =====
// Assertion macros used by the point-in-polygon controller.
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication under an active-low reset.
`define PIPT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("point_in_polygon_test: assertion failed");

// Next-cycle implication under an active-low reset.
`define PIPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("point_in_polygon_test: assertion failed");

`else

`define PIPT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PIPT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/pipt_pkg.sv =====
package pipt_pkg;

    localparam int MAX_VERTICES_DEF = 64;

    localparam int COORD_W  = 32;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int VERTEX_W = 2 * COORD_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Word index of the vertex_count configuration register
    localparam logic [APB_ADDR_W-3:0] REG_VERTEX_COUNT = 1'b0;

    // Item modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    // Read issue from the sequencer to the edge unit
    typedef struct packed {
        logic start;
        logic rd_en;
        logic first;
    } issue_t;

endpackage

// ===== design/pipt_if.sv =====
interface pipt_query_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [pipt_pkg::INDEX_W-1:0]   vertex_index;
    pipt_pkg::coord_t               coord_x;
    pipt_pkg::coord_t               coord_y;

    modport source (output valid, output mode, output vertex_index, output coord_x,
                    output coord_y, input ready);
    modport sink (input valid, input mode, input vertex_index, input coord_x,
                  input coord_y, output ready);
endinterface

interface pipt_answer_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, output inside_res, input ready);
    modport sink (input valid, input inside_res, output ready);
endinterface

// ===== design/pipt_ram.sv =====
module pipt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/pipt_edge_unit.sv =====
module pipt_edge_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pipt_pkg::issue_t                  issue,
    input  pipt_pkg::coord_t                  qx,
    input  pipt_pkg::coord_t                  qy,
    input  logic [pipt_pkg::VERTEX_W-1:0]     rd_data,
    output logic                              busy,
    output logic                              in_poly
);

    // Query point
    pipt_pkg::coord_t q_x_reg;
    pipt_pkg::coord_t q_y_reg;

    // Stage 0: RAM data arrives
    logic s0_vld_reg;
    logic s0_first_reg;
    pipt_pkg::coord_t prev_x_reg;
    pipt_pkg::coord_t prev_y_reg;

    // Stage 1: differences
    logic s1_vld_reg;
    logic s1_cross_reg;
    logic s1_dyneg_reg;
    pipt_pkg::diff_t dxq_reg;
    pipt_pkg::diff_t dy_reg;
    pipt_pkg::diff_t dxe_reg;
    pipt_pkg::diff_t dyq_reg;

    // Stage 2: products
    logic s2_vld_reg;
    logic s2_cross_reg;
    logic s2_dyneg_reg;
    pipt_pkg::prod_t lhs_reg;
    pipt_pkg::prod_t rhs_reg;

    logic in_poly_reg;
    logic in_poly_next;

    pipt_pkg::coord_t cur_x;
    pipt_pkg::coord_t cur_y;
    logic             edge_vld;
    logic             above_i;
    logic             above_j;
    pipt_pkg::diff_t  dxq_next;
    pipt_pkg::diff_t  dy_next;
    pipt_pkg::diff_t  dxe_next;
    pipt_pkg::diff_t  dyq_next;
    pipt_pkg::prod_t  lhs_next;
    pipt_pkg::prod_t  rhs_next;
    logic             hit;

    assign cur_x    = rd_data[pipt_pkg::COORD_W-1:0];
    assign cur_y    = rd_data[pipt_pkg::VERTEX_W-1:pipt_pkg::COORD_W];
    assign edge_vld = s0_vld_reg && !s0_first_reg;

    // Edge runs from the current vertex i back to the previous vertex j
    always_comb
    begin
        above_i  = cur_y > q_y_reg;
        above_j  = prev_y_reg > q_y_reg;
        dxq_next = $signed({q_x_reg[31], q_x_reg}) - $signed({cur_x[31], cur_x});
        dy_next  = $signed({prev_y_reg[31], prev_y_reg}) - $signed({cur_y[31], cur_y});
        dxe_next = $signed({prev_x_reg[31], prev_x_reg}) - $signed({cur_x[31], cur_x});
        dyq_next = $signed({q_y_reg[31], q_y_reg}) - $signed({cur_y[31], cur_y});
    end

    assign lhs_next = dxq_reg * dy_reg;
    assign rhs_next = dxe_reg * dyq_reg;

    // Flip the compare for a downward edge
    assign hit = s2_dyneg_reg ? (rhs_reg < lhs_reg) : (lhs_reg < rhs_reg);

    always_comb
    begin
        in_poly_next = in_poly_reg;
        if (issue.start)
        begin
            in_poly_next = 1'b0;
        end
        else if (s2_vld_reg && s2_cross_reg && hit)
        begin
            in_poly_next = !in_poly_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg   <= 1'b0;
            s0_first_reg <= 1'b0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            in_poly_reg  <= 1'b0;
        end
        else
        begin
            s0_vld_reg   <= issue.rd_en;
            s0_first_reg <= issue.first;
            s1_vld_reg   <= edge_vld;
            s2_vld_reg   <= s1_vld_reg;
            in_poly_reg  <= in_poly_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue.start)
        begin
            q_x_reg <= qx;
            q_y_reg <= qy;
        end
        if (s0_vld_reg)
        begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
        s1_cross_reg <= above_i != above_j;
        s1_dyneg_reg <= dy_next[pipt_pkg::DIFF_W-1];
        dxq_reg      <= dxq_next;
        dy_reg       <= dy_next;
        dxe_reg      <= dxe_next;
        dyq_reg      <= dyq_next;
        s2_cross_reg <= s1_cross_reg;
        s2_dyneg_reg <= s1_dyneg_reg;
        lhs_reg      <= lhs_next;
        rhs_reg      <= rhs_next;
    end

    assign busy    = s0_vld_reg || s1_vld_reg || s2_vld_reg;
    assign in_poly = in_poly_reg;

endmodule

// ===== design/pipt_ctrl.sv =====
`include "point_in_polygon_test_macros.svh"

module pipt_ctrl #(
    parameter int MAX_VERTICES = pipt_pkg::MAX_VERTICES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_fire,
    input  logic                              in_mode,
    input  logic [pipt_pkg::INDEX_W-1:0]      in_index,
    input  logic [pipt_pkg::COUNT_W-1:0]      vertex_count,
    input  logic                              out_ready,
    input  logic                              edge_busy,
    input  logic                              in_poly,
    output logic                              in_ready,
    output logic                              out_valid,
    output logic                              out_inside,
    output logic                              ram_we,
    output logic [$clog2(MAX_VERTICES)-1:0]   ram_waddr,
    output logic [$clog2(MAX_VERTICES)-1:0]   ram_raddr,
    output pipt_pkg::issue_t                  issue
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    pipt_pkg::state_t state_reg;
    pipt_pkg::state_t state_next;
    logic [CW-1:0]    n_reg;
    logic [CW-1:0]    n_next;
    logic [CW-1:0]    k_reg;
    logic [CW-1:0]    k_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_inside_reg;
    logic             out_inside_next;

    logic [CW-1:0]    n_clamp;
    logic [CW-1:0]    nm1;
    logic [CW-1:0]    km1;
    logic [CW-1:0]    rd_idx;
    logic             out_load;

    assign n_clamp = (32'(vertex_count) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                        : CW'(vertex_count);
    assign nm1     = n_reg - CW'(1);
    assign km1     = k_reg - CW'(1);
    // First read fetches the last vertex, then vertices from zero upward
    assign rd_idx    = (k_reg == '0) ? nm1 : km1;
    assign ram_raddr = rd_idx[AW-1:0];

    assign in_ready  = state_reg == pipt_pkg::ST_IDLE;
    assign ram_we    = in_fire && (in_mode == pipt_pkg::MODE_WRITE)
                       && (32'(in_index) < MAX_VERTICES);
    assign ram_waddr = AW'(in_index);

    // Hold the result until the output register is free
    assign out_load  = (state_reg == pipt_pkg::ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_inside_next = out_inside_reg;
        issue           = '0;
        case (state_reg)
            pipt_pkg::ST_IDLE:
            begin
                if (in_fire && (in_mode == pipt_pkg::MODE_QUERY))
                begin
                    issue.start = 1'b1;
                    n_next      = n_clamp;
                    k_next      = '0;
                    state_next  = (n_clamp == '0) ? pipt_pkg::ST_DONE : pipt_pkg::ST_WALK;
                end
            end
            pipt_pkg::ST_WALK:
            begin
                issue.rd_en = 1'b1;
                issue.first = k_reg == '0;
                k_next      = k_reg + CW'(1);
                if (k_reg == n_reg)
                begin
                    state_next = pipt_pkg::ST_DRAIN;
                end
            end
            pipt_pkg::ST_DRAIN:
            begin
                if (!edge_busy)
                begin
                    state_next = pipt_pkg::ST_DONE;
                end
            end
            pipt_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_inside_next = in_poly;
                    state_next      = pipt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pipt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pipt_pkg::ST_IDLE;
            n_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_inside_reg <= out_inside_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_inside = out_inside_reg;

    `PIPT_ASSERT_IMPLY(a_idle_not_busy, clk, rst_n, in_ready, !edge_busy)
    `PIPT_ASSERT_IMPLY(a_read_in_range, clk, rst_n, issue.rd_en, 32'(ram_raddr) < 32'(n_reg))
    `PIPT_ASSERT_IMPLY(a_write_when_idle, clk, rst_n, ram_we, in_ready)
    `PIPT_ASSERT_NEXT(a_done_loads_out, clk, rst_n, out_load, out_valid_reg && in_ready)

endmodule

// ===== design/point_in_polygon_test.sv =====
// Point-in-polygon tester: ray casting over a vertex table in one RAM.
// A vertex write item does not leave idle, so the block stays ready for further items.
// A query walks the vertex table (n = clamped vertex_count) through the single RAM read port,
// which fetches one vertex per cycle into the edge pipeline.
// One query is in flight at a time; a count of zero skips the walk and goes straight to the result.
// Reset (rst_n, async, active low) clears control state and vertex_count; table is not cleared.
module point_in_polygon_test #(
    parameter int MAX_VERTICES = pipt_pkg::MAX_VERTICES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    pipt_query_if.sink                          query,
    pipt_answer_if.source                       answer,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pipt_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pipt_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pipt_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int AW = $clog2(MAX_VERTICES);

    logic [pipt_pkg::COUNT_W-1:0] vertex_count_reg;
    logic                         reg_hit;
    logic                         q_fire;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [AW-1:0]                ram_raddr;
    logic [pipt_pkg::VERTEX_W-1:0] ram_rdata;
    pipt_pkg::issue_t             issue;
    logic                         edge_busy;
    logic                         in_poly;

    assign pready  = 1'b1;
    assign reg_hit = paddr[pipt_pkg::APB_ADDR_W-1:2] == pipt_pkg::REG_VERTEX_COUNT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            vertex_count_reg <= pwdata[pipt_pkg::COUNT_W-1:0];
        end
    end

    assign prdata = reg_hit ? pipt_pkg::APB_DATA_W'(vertex_count_reg) : '0;

    assign q_fire = query.valid && query.ready;

    pipt_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (q_fire),
        .in_mode      (query.mode),
        .in_index     (query.vertex_index),
        .vertex_count (vertex_count_reg),
        .out_ready    (answer.ready),
        .edge_busy    (edge_busy),
        .in_poly      (in_poly),
        .in_ready     (query.ready),
        .out_valid    (answer.valid),
        .out_inside   (answer.inside_res),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_raddr    (ram_raddr),
        .issue        (issue)
    );

    pipt_ram #(
        .WIDTH (pipt_pkg::VERTEX_W),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({query.coord_y, query.coord_x}),
        .re    (issue.rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pipt_edge_unit u_edge (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue   (issue),
        .qx      (query.coord_x),
        .qy      (query.coord_y),
        .rd_data (ram_rdata),
        .busy    (edge_busy),
        .in_poly (in_poly)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import pipt_pkg::*;

    localparam int NUM_SLOTS   = MAX_VERTICES_DEF;
    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 80;
    localparam logic [APB_ADDR_W-1:0] COUNT_ADDR = {REG_VERTEX_COUNT, 2'b00};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t DEG5      = 32'sh0280_0000;
    localparam coord_t DEG10     = 32'sh0500_0000;
    localparam coord_t DEG20     = 32'sh0A00_0000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pipt_query_if  query_ch();
    pipt_answer_if answer_ch();

    point_in_polygon_test uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .query   (query_ch),
        .answer  (answer_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Local copy of the vertex table and the count register
    coord_t             poly_x [NUM_SLOTS];
    coord_t             poly_y [NUM_SLOTS];
    bit                 slot_written [NUM_SLOTS];
    logic [COUNT_W-1:0] cfg_count = '0;
    bit                 inside_expect [$];

    int error_count    = 0;
    int items_sent     = 0;
    int queries_sent   = 0;
    int writes_sent    = 0;
    int answers_seen   = 0;
    int inside_seen    = 0;
    int config_writes  = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Even-odd ray cast with cross-multiplied crossing test
    function automatic bit ray_cast_inside(coord_t qx, coord_t qy);
        int    n;
        int    j;
        bit    in_poly;
        bit    hit;
        diff_t dy;
        diff_t dxq;
        diff_t dxe;
        diff_t dyq;
        prod_t lhs;
        prod_t rhs;
        n = (cfg_count > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_count);
        in_poly = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            j = (i == 0) ? n - 1 : i - 1;
            if ((poly_y[i] > qy) != (poly_y[j] > qy))
            begin
                dy  = poly_y[j] - poly_y[i];
                dxq = qx - poly_x[i];
                dxe = poly_x[j] - poly_x[i];
                dyq = qy - poly_y[i];
                lhs = dxq * dy;
                rhs = dxe * dyq;
                hit = (dy < 0) ? (rhs < lhs) : (lhs < rhs);
                if (hit)
                    in_poly = !in_poly;
            end
        end
        return in_poly;
    endfunction

    function automatic coord_t rand_coord(coord_t center, int shift);
        case ($urandom_range(31))
            0: return COORD_MIN;
            1: return COORD_MAX;
            default: return center + (coord_t'($urandom) >>> shift);
        endcase
    endfunction

    task automatic send_item(logic mode, logic [INDEX_W-1:0] idx, coord_t x, coord_t y);
        if ($urandom_range(99) < src_idle_pct)
        begin
            query_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        query_ch.valid        <= 1'b1;
        query_ch.mode         <= mode;
        query_ch.vertex_index <= idx;
        query_ch.coord_x      <= x;
        query_ch.coord_y      <= y;
        do @(posedge clk); while (!query_ch.ready);
        items_sent++;
        if (mode == MODE_WRITE)
        begin
            poly_x[idx]       = x;
            poly_y[idx]       = y;
            slot_written[idx] = 1'b1;
            writes_sent++;
        end
        else
        begin
            inside_expect.push_back(ray_cast_inside(x, y));
            queries_sent++;
        end
    endtask

    task automatic send_query(coord_t x, coord_t y);
        send_item(MODE_QUERY, INDEX_W'($urandom_range(NUM_SLOTS - 1)), x, y);
    endtask

    // Drop valid and let every pending answer come back
    task automatic drain;
        query_ch.valid <= 1'b0;
        while (inside_expect.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Write vertex_count, then read it back in a second transfer
    task automatic set_vertex_count(logic [COUNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COUNT_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        cfg_count = value;
        config_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== APB_DATA_W'(value))
            report_mismatch($sformatf("vertex_count read %0h, written %0h", prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_empty_polygon;
        set_vertex_count('0);
        send_query('0, '0);
        send_query(COORD_MIN, COORD_MIN);
        send_query(COORD_MAX, COORD_MAX);
        send_query(COORD_MIN, COORD_MAX);
        drain();
    endtask

    task automatic test_directed_shapes;
        // Square spanning the full coordinate range
        send_item(MODE_WRITE, 6'd0, COORD_MIN, COORD_MIN);
        send_item(MODE_WRITE, 6'd1, COORD_MAX, COORD_MIN);
        send_item(MODE_WRITE, 6'd2, COORD_MAX, COORD_MAX);
        send_item(MODE_WRITE, 6'd3, COORD_MIN, COORD_MAX);
        drain();
        set_vertex_count(COUNT_W'(4));
        send_query('0, '0);
        send_query(COORD_MIN, '0);
        send_query(COORD_MAX, '0);
        send_query('0, COORD_MIN);
        send_query('0, COORD_MAX);
        send_query(COORD_MIN, COORD_MIN);
        send_query(coord_t'(-1), coord_t'(1));
        drain();
        // One vertex: a zero-length edge never straddles
        set_vertex_count(COUNT_W'(1));
        send_query(COORD_MIN, COORD_MIN);
        drain();
        // Triangle with a horizontal base and a point exactly on a slanted edge
        send_item(MODE_WRITE, 6'd0, '0, DEG20);
        send_item(MODE_WRITE, 6'd1, DEG10, -DEG10);
        send_item(MODE_WRITE, 6'd2, -DEG10, -DEG10);
        drain();
        set_vertex_count(COUNT_W'(3));
        send_query('0, '0);
        send_query('0, -DEG10);
        send_query(DEG5, DEG5);
        drain();
    endtask

    task automatic test_full_table;
        coord_t cx;
        coord_t cy;
        cx = coord_t'($urandom) >>> 2;
        cy = coord_t'($urandom) >>> 2;
        for (int i = 0; i < NUM_SLOTS; i++)
            send_item(MODE_WRITE, INDEX_W'(i), rand_coord(cx, 4), rand_coord(cy, 4));
        drain();
        // Counts above the table size clamp to a full table
        set_vertex_count({COUNT_W{1'b1}});
        for (int q = 0; q < 8; q++)
            send_query(rand_coord(cx, 4), rand_coord(cy, 4));
        drain();
        set_vertex_count(COUNT_W'(NUM_SLOTS));
        for (int q = 0; q < 8; q++)
            send_query(rand_coord(cx, 4), rand_coord(cy, 4));
        drain();
    endtask

    task automatic polygon_round;
        int     k;
        int     m;
        int     shift;
        int     prefix;
        int     v;
        int     pick;
        coord_t cx;
        coord_t cy;
        logic [COUNT_W-1:0] count;
        k = ($urandom_range(7) == 0) ? $urandom_range(13, NUM_SLOTS) : $urandom_range(3, 12);
        case ($urandom_range(4))
            0: shift = 1;
            1: shift = 4;
            2: shift = 12;
            3: shift = 20;
            default: shift = 26;
        endcase
        cx = coord_t'($urandom) >>> 1;
        cy = coord_t'($urandom) >>> 1;
        for (int i = 0; i < k; i++)
            send_item(MODE_WRITE, INDEX_W'(i), rand_coord(cx, shift), rand_coord(cy, shift));
        drain();
        prefix = 0;
        while (prefix < NUM_SLOTS && slot_written[prefix])
            prefix++;
        pick = $urandom_range(9);
        if (pick == 0)
            count = COUNT_W'($urandom_range(2));
        else if (pick == 1 && prefix == NUM_SLOTS)
            count = COUNT_W'($urandom_range(NUM_SLOTS, (1 << COUNT_W) - 1));
        else
            count = COUNT_W'(k);
        set_vertex_count(count);
        m = $urandom_range(4, 16);
        for (int q = 0; q < m; q++)
        begin
            pick = $urandom_range(9);
            v = $urandom_range(k - 1);
            if (pick == 0)
                send_item(MODE_WRITE, INDEX_W'($urandom_range(NUM_SLOTS - 1)),
                          coord_t'($urandom), coord_t'($urandom));
            else if (pick == 1)
                send_query(poly_x[v], poly_y[v]);
            else if (pick == 2)
                send_query(rand_coord(poly_x[v], shift), poly_y[v]);
            else
                send_query(rand_coord(cx, shift), rand_coord(cy, shift));
        end
        drain();
    endtask

    task automatic test_random_phase(int src_pct, int sink_pct, int n_items);
        int target;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        target = items_sent + n_items;
        while (items_sent < target)
            polygon_round();
    endtask

    // Hold the answer side off while queries keep coming, so the input stalls
    task automatic test_backpressure;
        coord_t cx;
        coord_t cy;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        cx = poly_x[0];
        cy = poly_y[0];
        hold_req++;
        for (int q = 0; q < 24; q++)
            send_query(rand_coord(cx, 8), rand_coord(cy, 8));
        drain();
    endtask

    // Answer side: random stalls, or a long hold when requested
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen       <= hold_req;
            hold_left       <= HOLD_CYCLES;
            answer_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left       <= hold_left - 1;
            answer_ch.ready <= 1'b0;
        end
        else
            answer_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        bit want;
        if (rst_n && answer_ch.valid && answer_ch.ready)
        begin
            if (inside_expect.size() == 0)
                report_mismatch("answer with no query pending");
            else
            begin
                want = inside_expect.pop_front();
                answers_seen++;
                if (answer_ch.inside_res === 1'b1)
                    inside_seen++;
                if (answer_ch.inside_res !== want)
                    report_mismatch($sformatf("inside_res %b, predicted %b",
                                              answer_ch.inside_res, want));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((query_ch.valid && query_ch.ready) || (answer_ch.valid && answer_ch.ready) ||
            (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        query_ch.valid         = 1'b0;
        query_ch.mode          = MODE_WRITE;
        query_ch.vertex_index  = '0;
        query_ch.coord_x       = '0;
        query_ch.coord_y       = '0;
        answer_ch.ready        = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_polygon();
        test_directed_shapes();
        test_full_table();
        test_random_phase(0, 0, 440);
        test_random_phase(71, 0, 440);
        test_random_phase(0, 71, 440);
        test_random_phase(16, 16, 440);
        test_backpressure();

        query_ch.valid <= 1'b0;
        while (inside_expect.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d vertex writes and %0d queries (%0d answered, %0d inside)",
                 writes_sent, queries_sent, answers_seen, inside_seen);
        $display("across %0d vertex_count settings, with idle and stall mixes and a long hold",
                 config_writes);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== point_in_polygon_test.f =====
+incdir+design
design/pipt_pkg.sv
design/pipt_if.sv
design/pipt_ram.sv
design/pipt_edge_unit.sv
design/pipt_ctrl.sv
design/point_in_polygon_test.sv
tb/testbench.sv
